// File: rtl/paq_pkg.sv
// Package for the PIE queue manager: sizes, constants, codes and payload types.
// Used by paq_cfg, paq_front, paq_back and pie_aqm_queue; depends on nothing.
package paq_pkg;

    // Descriptor store geometry
    localparam int QUEUE_DEPTH = 1024;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = TAG_BITS + 32;

    // Probability constants, Q1.31
    localparam logic [31:0] PROB_ONE       = 32'h8000_0000;
    localparam logic [31:0] PROB_POINT_TWO = 32'd429496730;

    // floor(2^37 / 50) for the 0.98 decay
    localparam logic [63:0] RECIP_50    = 64'd2748779069;
    localparam int          RECIP_SHIFT = 37;

    // Config port
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ECN_ENABLE   = 3'd0,
        REG_QDELAY_REF   = 3'd1,
        REG_MAX_BURST    = 3'd2,
        REG_BUFFER_LIMIT = 3'd3,
        REG_ALPHA_GAIN   = 3'd4,
        REG_BETA_GAIN    = 3'd5,
        REG_UPDATE_INTV  = 3'd6,
        REG_MARK_THRESH  = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_MARKED    = 3'd1,
        ST_EARLY_DROP = 3'd2,
        ST_FULL_DROP = 3'd3,
        ST_DEQUEUED  = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_UPDATED   = 3'd6
    } status_t;

    // Input mode codes
    localparam logic [1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    typedef enum logic [1:0] {
        OP_ARRIVAL,
        OP_DEQUEUE,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DQ_DATA,
        BK_TK_MA,
        BK_TK_MB,
        BK_TK_SUM,
        BK_TK_ADD,
        BK_TK_DEC1,
        BK_TK_DEC2
    } back_state_t;

    typedef struct packed {
        logic        ecn_enable;
        logic [15:0] qdelay_ref_ms;
        logic [15:0] max_burst_ms;
        logic [10:0] buffer_limit;
        logic [30:0] alpha_gain;
        logic [30:0] beta_gain;
        logic [9:0]  update_interval_ms;
        logic [31:0] mark_threshold;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [15:0] packet_tag;
        logic [1:0]  ecn_in;
        logic [30:0] random_value;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] tag_out;
        logic [1:0]  ecn_out;
        logic [15:0] queue_delay_ms;
        logic [31:0] drop_probability;
        logic [15:0] burst_left_ms;
        logic [10:0] fill_level;
    } result_t;

    // Classified command held between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [15:0] packet_tag;
        logic [1:0]  ecn_in;
        logic [30:0] random_value;
    } work_t;

    // Right shift applied to the PI correction, by probability range
    function automatic logic [3:0] scale_shift(input logic [31:0] prob);
        logic [3:0] s;
        if (prob < 32'd2148)
            s = 4'd11;
        else if (prob < 32'd21475)
            s = 4'd9;
        else if (prob < 32'd214749)
            s = 4'd7;
        else if (prob < 32'd2147484)
            s = 4'd5;
        else if (prob < 32'd21474837)
            s = 4'd3;
        else if (prob < 32'd214748365)
            s = 4'd1;
        else
            s = 4'd0;
        return s;
    endfunction

endpackage

// File: rtl/paq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module paq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/paq_cfg.sv
// APB-style configuration registers of the PIE queue manager.
// Depends on paq_pkg.
module paq_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [paq_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output paq_pkg::cfg_t                   cfg
);
    import paq_pkg::*;

    cfg_t       cfg_reg;
    cfg_index_t idx;
    logic       wr_en;

    assign idx    = cfg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ecn_enable         <= 1'b0;
            cfg_reg.qdelay_ref_ms      <= 16'd15;
            cfg_reg.max_burst_ms       <= 16'd150;
            cfg_reg.buffer_limit       <= 11'd1024;
            cfg_reg.alpha_gain         <= 31'd268435;
            cfg_reg.beta_gain          <= 31'd2684355;
            cfg_reg.update_interval_ms <= 10'd15;
            cfg_reg.mark_threshold     <= 32'd214748365;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ECN_ENABLE:   cfg_reg.ecn_enable         <= pwdata[0];
                REG_QDELAY_REF:   cfg_reg.qdelay_ref_ms      <= pwdata[15:0];
                REG_MAX_BURST:    cfg_reg.max_burst_ms       <= pwdata[15:0];
                REG_BUFFER_LIMIT: cfg_reg.buffer_limit       <= pwdata[10:0];
                REG_ALPHA_GAIN:   cfg_reg.alpha_gain         <= pwdata[30:0];
                REG_BETA_GAIN:    cfg_reg.beta_gain          <= pwdata[30:0];
                REG_UPDATE_INTV:  cfg_reg.update_interval_ms <= pwdata[9:0];
                REG_MARK_THRESH:  cfg_reg.mark_threshold     <= pwdata;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_ECN_ENABLE:   prdata = {31'd0, cfg_reg.ecn_enable};
            REG_QDELAY_REF:   prdata = {16'd0, cfg_reg.qdelay_ref_ms};
            REG_MAX_BURST:    prdata = {16'd0, cfg_reg.max_burst_ms};
            REG_BUFFER_LIMIT: prdata = {21'd0, cfg_reg.buffer_limit};
            REG_ALPHA_GAIN:   prdata = {1'b0, cfg_reg.alpha_gain};
            REG_BETA_GAIN:    prdata = {1'b0, cfg_reg.beta_gain};
            REG_UPDATE_INTV:  prdata = {22'd0, cfg_reg.update_interval_ms};
            REG_MARK_THRESH:  prdata = cfg_reg.mark_threshold;
        endcase
    end

endmodule

// File: rtl/paq_front.sv
// Front end: accepts commands, classifies the mode and queues them two deep.
// Depends on paq_pkg.
module paq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  paq_pkg::cmd_t   cmd,
    output logic            work_valid,
    output paq_pkg::work_t  work,
    input  logic            work_pop
);
    import paq_pkg::*;

    work_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       known;
    logic       do_wr;
    logic       do_rd;
    work_t      incoming;

    // Classify the mode; the unused code is taken and discarded
    always_comb
    begin
        incoming.now_ms       = cmd.now_ms;
        incoming.packet_tag   = cmd.packet_tag;
        incoming.ecn_in       = cmd.ecn_in;
        incoming.random_value = cmd.random_value;
        known                 = 1'b1;
        unique case (cmd.mode)
            MODE_ARRIVAL: incoming.op = OP_ARRIVAL;
            MODE_DEQUEUE: incoming.op = OP_DEQUEUE;
            MODE_TICK:    incoming.op = OP_TICK;
            default:
            begin
                incoming.op = OP_TICK;
                known       = 1'b0;
            end
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign work_valid = (count_reg != 2'd0);
    assign work       = slot_reg[rd_ptr_reg];
    assign do_wr      = push && !full && known;
    assign do_rd      = work_pop && work_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// File: rtl/paq_back.sv
// Back end: executes arrivals, dequeues and PI ticks; owns queue state,
// descriptor RAM and the result register. Depends on paq_pkg and paq_ram.
module paq_back (
    input  logic             clk,
    input  logic             rst_n,
    input  paq_pkg::cfg_t    cfg,
    input  logic             work_valid,
    input  paq_pkg::work_t   work,
    output logic             work_pop,
    output logic             empty,
    input  logic             pop,
    output paq_pkg::result_t result
);
    import paq_pkg::*;

    back_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [31:0]         prob_reg, prob_next;
    logic [15:0]         dnow_reg, dnow_next;
    logic [15:0]         dbef_reg, dbef_next;
    logic [15:0]         burst_reg, burst_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    // Work registers
    logic [31:0]         now_reg, now_next;
    logic signed [48:0]  pa_reg, pa_next;
    logic signed [48:0]  pb_reg, pb_next;
    logic signed [49:0]  ps_reg, ps_next;
    logic signed [50:0]  sum_reg, sum_next;
    logic [31:0]         y_reg, y_next;
    logic [63:0]         prod_reg, prod_next;
    logic                decay_reg, decay_next;

    // RAM port
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Arrival decision
    logic [15:0]         half_ref;
    logic [15:0]         burst_arr;
    logic                capable;
    logic                skip;
    logic                take;
    logic                marked;
    logic                dropped;
    logic [FILL_W-1:0]   limit;
    logic                at_limit;
    logic                start;

    // Tick datapath
    logic signed [16:0]  e1;
    logic signed [16:0]  e2;
    logic signed [48:0]  prod_a;
    logic signed [48:0]  prod_b;
    logic [49:0]         mag;
    logic [49:0]         shifted;
    logic signed [50:0]  adj;
    logic [31:0]         q_est;
    logic [31:0]         rem;
    logic [31:0]         q_fix;
    logic signed [50:0]  final_val;
    logic [31:0]         prob_new;
    logic [15:0]         burst_tick;

    // Dequeue delay
    logic [31:0]         delta;
    logic [15:0]         delay_sat;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    tail_inc;

    paq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {TAG_BITS'(work.packet_tag), work.now_ms};
    assign empty     = !res_valid_reg;
    assign result    = res_reg;
    assign start     = work_valid && (state_reg == BK_IDLE) && !res_valid_reg;
    assign work_pop  = start;

    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // Burst refresh, early drop / mark and tail-drop limit
    always_comb
    begin
        half_ref  = cfg.qdelay_ref_ms >> 1;
        burst_arr = (prob_reg == 32'd0 && dnow_reg < half_ref && dbef_reg < half_ref)
                    ? cfg.max_burst_ms : burst_reg;
        capable   = cfg.ecn_enable && (work.ecn_in == 2'd1 || work.ecn_in == 2'd2);
        skip      = (dbef_reg < half_ref && prob_reg < PROB_POINT_TWO)
                    || (fill_reg <= FILL_W'(2));
        take      = (burst_arr == 16'd0) && !skip && ({1'b0, work.random_value} <= prob_reg);
        marked    = take && capable && (prob_reg <= cfg.mark_threshold);
        dropped   = take && !marked;
        limit     = (32'(cfg.buffer_limit) < 32'(QUEUE_DEPTH))
                    ? FILL_W'(cfg.buffer_limit) : FILL_W'(QUEUE_DEPTH);
        at_limit  = (fill_reg >= limit);
    end

    // Sojourn delay, saturated
    assign delta     = now_reg - ram_rdata[31:0];
    assign delay_sat = (delta[31:16] != 16'd0) ? 16'hFFFF : delta[15:0];

    // PI terms
    assign e1     = $signed({1'b0, dnow_reg}) - $signed({1'b0, cfg.qdelay_ref_ms});
    assign e2     = $signed({1'b0, dnow_reg}) - $signed({1'b0, dbef_reg});
    assign prod_a = $signed({1'b0, cfg.alpha_gain}) * e1;
    assign prod_b = $signed({1'b0, cfg.beta_gain}) * e2;

    // Scaled correction added to probability
    always_comb
    begin
        mag     = ps_reg[49] ? 50'(-ps_reg) : 50'(ps_reg);
        shifted = mag >> scale_shift(prob_reg);
        adj     = ps_reg[49] ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
    end

    // Decay by 49/50: s - ceil(s/50), with quotient via reciprocal
    always_comb
    begin
        q_est = 32'(prod_reg >> RECIP_SHIFT);
        rem   = y_reg - q_est * 32'd50;
        q_fix = (rem >= 32'd50) ? q_est + 32'd1 : q_est;
        final_val = decay_reg ? sum_reg - $signed({19'd0, q_fix}) : sum_reg;
        if (final_val[50])
            prob_new = 32'd0;
        else if (final_val > $signed({19'd0, PROB_ONE}))
            prob_new = PROB_ONE;
        else
            prob_new = final_val[31:0];
        burst_tick = (burst_reg <= 16'(cfg.update_interval_ms))
                     ? 16'd0 : burst_reg - 16'(cfg.update_interval_ms);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        prob_next      = prob_reg;
        dnow_next      = dnow_reg;
        dbef_next      = dbef_reg;
        burst_next     = burst_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        now_next       = now_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        ps_next        = ps_reg;
        sum_next       = sum_reg;
        y_next         = y_reg;
        prod_next      = prod_reg;
        decay_next     = decay_reg;
        ram_we         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    unique case (work.op)
                        OP_ARRIVAL:
                        begin
                            burst_next = burst_arr;
                            res_next.tag_out = work.packet_tag;
                            res_next.ecn_out = marked ? 2'd3 : work.ecn_in;
                            if (dropped)
                                res_next.status = ST_EARLY_DROP;
                            else if (at_limit)
                                res_next.status = ST_FULL_DROP;
                            else
                            begin
                                ram_we = 1'b1;
                                tail_next = tail_inc;
                                fill_next = fill_reg + 1'b1;
                                res_next.status = marked ? ST_MARKED : ST_ENQUEUED;
                            end
                            res_next.queue_delay_ms   = dnow_reg;
                            res_next.drop_probability = prob_reg;
                            res_next.burst_left_ms    = burst_arr;
                            res_next.fill_level       = 11'(fill_next);
                            res_valid_next = 1'b1;
                        end
                        OP_DEQUEUE:
                        begin
                            if (fill_reg != '0)
                            begin
                                now_next   = work.now_ms;
                                state_next = BK_DQ_DATA;
                            end
                            else
                            begin
                                dnow_next = 16'd0;
                                res_next.status           = ST_EMPTY;
                                res_next.tag_out          = 16'd0;
                                res_next.ecn_out          = 2'd0;
                                res_next.queue_delay_ms   = 16'd0;
                                res_next.drop_probability = prob_reg;
                                res_next.burst_left_ms    = burst_reg;
                                res_next.fill_level       = 11'(fill_reg);
                                res_valid_next = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = BK_TK_MA;
                        end
                    endcase
                end
            end
            BK_DQ_DATA:
            begin
                dnow_next = delay_sat;
                head_next = head_inc;
                fill_next = fill_reg - 1'b1;
                res_next.status           = ST_DEQUEUED;
                res_next.tag_out          = 16'(ram_rdata[ENTRY_W-1:32]);
                res_next.ecn_out          = 2'd0;
                res_next.queue_delay_ms   = delay_sat;
                res_next.drop_probability = prob_reg;
                res_next.burst_left_ms    = burst_reg;
                res_next.fill_level       = 11'(fill_next);
                res_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end
            BK_TK_MA:
            begin
                pa_next    = prod_a;
                state_next = BK_TK_MB;
            end
            BK_TK_MB:
            begin
                pb_next    = prod_b;
                state_next = BK_TK_SUM;
            end
            BK_TK_SUM:
            begin
                ps_next    = 50'(pa_reg) + 50'(pb_reg);
                state_next = BK_TK_ADD;
            end
            BK_TK_ADD:
            begin
                sum_next   = $signed({19'd0, prob_reg}) + adj;
                state_next = BK_TK_DEC1;
            end
            BK_TK_DEC1:
            begin
                decay_next = (dnow_reg == 16'd0) && (dbef_reg == 16'd0)
                             && !sum_reg[50] && (sum_reg != '0);
                y_next     = sum_reg[31:0] + 32'd49;
                prod_next  = 64'(y_next) * RECIP_50;
                state_next = BK_TK_DEC2;
            end
            BK_TK_DEC2:
            begin
                prob_next  = prob_new;
                dbef_next  = dnow_reg;
                burst_next = burst_tick;
                res_next.status           = ST_UPDATED;
                res_next.tag_out          = 16'd0;
                res_next.ecn_out          = 2'd0;
                res_next.queue_delay_ms   = dnow_reg;
                res_next.drop_probability = prob_new;
                res_next.burst_left_ms    = burst_tick;
                res_next.fill_level       = 11'(fill_reg);
                res_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            prob_reg      <= 32'd0;
            dnow_reg      <= 16'd0;
            dbef_reg      <= 16'd0;
            burst_reg     <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            prob_reg      <= prob_next;
            dnow_reg      <= dnow_next;
            dbef_reg      <= dbef_next;
            burst_reg     <= burst_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        now_reg   <= now_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        ps_reg    <= ps_next;
        sum_reg   <= sum_next;
        y_reg     <= y_next;
        prod_reg  <= prod_next;
        decay_reg <= decay_next;
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prob_reg <= PROB_ONE)
        else $error("probability above one");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !res_valid_reg)
        else $error("result pending while a command is in flight");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !pop) |=> (res_valid_reg && $stable(res_reg)))
        else $error("pending result lost or changed");

endmodule

// File: rtl/pie_aqm_queue.sv
// PIE active queue manager with packet descriptor FIFO, top level.
// Channels: command queue in (push/full, cmd), result queue out (empty/pop,
// result), APB-style config port. An arrival, dequeue or tick command is
// transferred when push is high and full is low; mode 3 is taken and gives
// no result. A result stays on the result port while empty is low and is
// transferred when pop is high.
// Result path: an arrival or empty dequeue writes the result register when it
// starts, a dequeue after a registered descriptor RAM read, a tick after two
// multiplies, correction sum, scaling add and the reciprocal decay steps DEC1
// and DEC2, one per cycle. The single execution sequencer takes no new command
// until the result of the last one has been popped; a two-entry command queue
// keeps accepting while the sequencer works or a result waits.
// If pop stays low, the held result blocks the sequencer and the command
// queue fills, raising full. Reset clears the queue, probability, delays
// and burst allowance and loads register defaults; no clearing pass.
// Depends on paq_pkg, paq_cfg, paq_front, paq_back, paq_ram.
module pie_aqm_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  paq_pkg::cmd_t                   cmd,
    output logic                            empty,
    input  logic                            pop,
    output paq_pkg::result_t                result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [paq_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import paq_pkg::*;

    cfg_t  cfg;
    work_t work;
    logic  work_valid;
    logic  work_pop;

    paq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    paq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop)
    );

    paq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: bench/tb_pie_aqm_queue.sv
// Self-checking testbench for pie_aqm_queue: directed and random command
// streams, with a cycle-free predictor of the PIE queue manager.
// Depends on rtl/paq_pkg.sv and the RTL of pie_aqm_queue.
`timescale 1ns / 100ps

module tb_pie_aqm_queue;
    import paq_pkg::*;

    localparam int DRAIN_CYCLES = 12;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    cmd_t             cmd;
    logic             empty;
    logic             pop;
    result_t          result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    pie_aqm_queue dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .empty(empty), .pop(pop), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // Predictor state
    logic [15:0] tag_mem [QUEUE_DEPTH];
    logic [31:0] arrive_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] rd_ptr, wr_ptr;
    int unsigned fill;
    logic [31:0] prob;
    logic [15:0] dly_now, dly_prev, burst;
    cfg_t        regs;

    result_t     pending_results[$];
    int          fail_count;
    bit          idle_on;
    int          stall_left;
    logic [31:0] clock_ms;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Magnitude shift, truncating toward zero
    function automatic longint shift_mag(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = m >>> s;
        return (v < 0) ? -m : m;
    endfunction

    // Expected result of one accepted command; mode 3 gives none
    task automatic pie_predict(input cmd_t c);
        result_t r;
        logic [15:0] half_ref;
        longint e1, e2, p, sum;
        logic [31:0] d;
        int unsigned lim;
        bit capable, marked, dropped, skip;
        r = '0;
        half_ref = regs.qdelay_ref_ms >> 1;
        marked = 0;
        dropped = 0;
        if (c.mode == MODE_ARRIVAL)
        begin
            capable = regs.ecn_enable && (c.ecn_in == 2'd1 || c.ecn_in == 2'd2);
            lim = (regs.buffer_limit < QUEUE_DEPTH) ? regs.buffer_limit : QUEUE_DEPTH;
            r.tag_out = c.packet_tag;
            r.ecn_out = c.ecn_in;
            if (prob == 0 && dly_now < half_ref && dly_prev < half_ref)
                burst = regs.max_burst_ms;
            if (burst == 0)
            begin
                skip = (dly_prev < half_ref && prob < PROB_POINT_TWO) || fill <= 2;
                if (!skip && {1'b0, c.random_value} <= prob)
                begin
                    if (capable && prob <= regs.mark_threshold)
                    begin
                        marked = 1;
                        r.ecn_out = 2'd3;
                    end
                    else
                        dropped = 1;
                end
            end
            if (dropped)
                r.status = ST_EARLY_DROP;
            else if (fill >= lim)
                r.status = ST_FULL_DROP;
            else
            begin
                tag_mem[wr_ptr] = c.packet_tag;
                arrive_mem[wr_ptr] = c.now_ms;
                wr_ptr++;
                fill++;
                r.status = marked ? ST_MARKED : ST_ENQUEUED;
            end
        end
        else if (c.mode == MODE_DEQUEUE)
        begin
            if (fill > 0)
            begin
                d = c.now_ms - arrive_mem[rd_ptr];
                r.tag_out = tag_mem[rd_ptr];
                dly_now = (d > 32'd65535) ? 16'hFFFF : d[15:0];
                rd_ptr++;
                fill--;
                r.status = ST_DEQUEUED;
            end
            else
            begin
                dly_now = '0;
                r.status = ST_EMPTY;
            end
        end
        else if (c.mode == MODE_TICK)
        begin
            e1 = longint'(dly_now) - longint'(regs.qdelay_ref_ms);
            e2 = longint'(dly_now) - longint'(dly_prev);
            p = longint'(regs.alpha_gain) * e1 + longint'(regs.beta_gain) * e2;
            if (prob < 32'd2148) p = shift_mag(p, 11);
            else if (prob < 32'd21475) p = shift_mag(p, 9);
            else if (prob < 32'd214749) p = shift_mag(p, 7);
            else if (prob < 32'd2147484) p = shift_mag(p, 5);
            else if (prob < 32'd21474837) p = shift_mag(p, 3);
            else if (prob < 32'd214748365) p = shift_mag(p, 1);
            sum = longint'(prob) + p;
            if (dly_now == 0 && dly_prev == 0 && sum > 0)
                sum = (sum * 49) / 50;
            if (sum < 0) sum = 0;
            if (sum > longint'(PROB_ONE)) sum = longint'(PROB_ONE);
            prob = sum[31:0];
            dly_prev = dly_now;
            if (burst <= regs.update_interval_ms) burst = '0;
            else burst = burst - regs.update_interval_ms;
            r.status = ST_UPDATED;
        end
        else
            return;
        r.queue_delay_ms = dly_now;
        r.drop_probability = prob;
        r.burst_left_ms = burst;
        r.fill_level = fill[10:0];
        pending_results.push_back(r);
    endtask

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Result side: compare each transfer, stall pop in random bursts
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no expectation waiting: status %0d", result.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, result.status);
                    check_field("tag_out", want.tag_out, result.tag_out);
                    check_field("ecn_out", want.ecn_out, result.ecn_out);
                    check_field("queue_delay_ms", want.queue_delay_ms, result.queue_delay_ms);
                    check_field("drop_probability", want.drop_probability,
                                result.drop_probability);
                    check_field("burst_left_ms", want.burst_left_ms, result.burst_left_ms);
                    check_field("fill_level", want.fill_level, result.fill_level);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // One command transfer, with an optional random gap first
    task automatic send_cmd(input logic [1:0] mode, input logic [31:0] now,
                            input logic [15:0] tag, input logic [1:0] ecn,
                            input logic [30:0] rnd);
        cmd_t c;
        c.mode = mode;
        c.now_ms = now;
        c.packet_tag = tag;
        c.ecn_in = ecn;
        c.random_value = rnd;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (full);
        pie_predict(c);
    endtask

    // Stop sending and wait until every expected result has come
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, only while the block is idle
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ECN_ENABLE:   regs.ecn_enable = value[0];
            REG_QDELAY_REF:   regs.qdelay_ref_ms = value[15:0];
            REG_MAX_BURST:    regs.max_burst_ms = value[15:0];
            REG_BUFFER_LIMIT: regs.buffer_limit = value[10:0];
            REG_ALPHA_GAIN:   regs.alpha_gain = value[30:0];
            REG_BETA_GAIN:    regs.beta_gain = value[30:0];
            REG_UPDATE_INTV:  regs.update_interval_ms = value[9:0];
            REG_MARK_THRESH:  regs.mark_threshold = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic ecn, input logic [15:0] qref,
                             input logic [15:0] mburst, input logic [10:0] blim,
                             input logic [30:0] alpha, input logic [30:0] beta,
                             input logic [9:0] intv, input logic [31:0] thresh);
        drain();
        write_reg(REG_ECN_ENABLE, 32'(ecn));
        write_reg(REG_QDELAY_REF, 32'(qref));
        write_reg(REG_MAX_BURST, 32'(mburst));
        write_reg(REG_BUFFER_LIMIT, 32'(blim));
        write_reg(REG_ALPHA_GAIN, 32'(alpha));
        write_reg(REG_BETA_GAIN, 32'(beta));
        write_reg(REG_UPDATE_INTV, 32'(intv));
        write_reg(REG_MARK_THRESH, thresh);
    endtask

    // Empty dequeue, unused mode, tick at rest, arrivals and dequeues,
    // delay saturation and time wrap
    task automatic test_basic_ops();
        send_cmd(MODE_DEQUEUE, 32'd5, 16'h0, 2'd0, 31'd0);
        send_cmd(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 31'h7FFF_FFFF);
        send_cmd(MODE_TICK, 32'd6, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_ARRIVAL, 32'hFFFF_FFF0, 16'hFFFF, 2'd3, 31'h7FFF_FFFF);
        send_cmd(MODE_ARRIVAL, 32'd0, 16'h0000, 2'd0, 31'd0);
        send_cmd(MODE_ARRIVAL, 32'd1, 16'hA5A5, 2'd1, 31'd0);
        send_cmd(MODE_DEQUEUE, 32'd20, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_DEQUEUE, 32'd200000, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_TICK, 32'd200001, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_DEQUEUE, 32'd200002, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_DEQUEUE, 32'd200003, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_TICK, 32'd200004, 16'h0, 2'd0, 31'd0);
    endtask

    // Tail drop at a tiny limit, and every arrival dropped at limit zero
    task automatic test_full_drop();
        write_all(1'b0, 16'd15, 16'd150, 11'd2, 31'd268435, 31'd2684355,
                  10'd15, 32'd214748365);
        repeat (4) send_cmd(MODE_ARRIVAL, 32'd10, 16'($urandom), 2'($urandom), 31'd5);
        write_all(1'b0, 16'd15, 16'd150, 11'd0, 31'd268435, 31'd2684355,
                  10'd15, 32'd214748365);
        send_cmd(MODE_ARRIVAL, 32'd11, 16'h1234, 2'd2, 31'd0);
        repeat (2) send_cmd(MODE_DEQUEUE, 32'd12, 16'h0, 2'd0, 31'd0);
    endtask

    // Drive probability up, then early drop and ECN mark decisions
    task automatic test_early_drop();
        write_all(1'b1, 16'd0, 16'd0, 11'd64, 31'h7FFF_FFFF, 31'd0,
                  10'd1000, 32'h8000_0000);
        repeat (5) send_cmd(MODE_ARRIVAL, 32'd100, 16'($urandom), 2'd1, 31'h7FFF_FFFF);
        send_cmd(MODE_DEQUEUE, 32'd400, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_TICK, 32'd401, 16'h0, 2'd0, 31'd0);
        send_cmd(MODE_ARRIVAL, 32'd402, 16'h1111, 2'd1, 31'd0);
        send_cmd(MODE_ARRIVAL, 32'd403, 16'h2222, 2'd0, 31'd0);
        send_cmd(MODE_ARRIVAL, 32'd404, 16'h3333, 2'd3, 31'h7FFF_FFFF);
    endtask

    // Random command mix; draws often land near the current probability
    task automatic random_phase(input int items);
        int roll;
        logic [1:0] mode;
        logic [30:0] rnd;
        repeat (items)
        begin
            roll = $urandom_range(0, 99);
            mode = (roll < 45) ? MODE_ARRIVAL : (roll < 80) ? MODE_DEQUEUE :
                   (roll < 96) ? MODE_TICK : 2'd3;
            if ($urandom_range(0, 30) == 0)
                clock_ms = clock_ms + $urandom_range(60000, 200000);
            else
                clock_ms = clock_ms + $urandom_range(0, 6);
            if ($urandom_range(0, 1))
                rnd = 31'($urandom_range(0, 32'(prob) + 1000));
            else
                rnd = 31'($urandom);
            send_cmd(mode, clock_ms, 16'($urandom), 2'($urandom), rnd);
        end
    endtask

    task automatic test_random();
        // extremes first: all minimum, then all maximum
        write_all(1'b0, 16'd0, 16'd0, 11'd0, 31'd0, 31'd0, 10'd1, 32'd0);
        random_phase(60);
        write_all(1'b1, 16'hFFFF, 16'hFFFF, 11'd1024, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  10'd1000, 32'h8000_0000);
        random_phase(80);
        clock_ms = 32'hFFFF_FF00;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7) idle_on = 0;
            write_all(1'($urandom), 16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                      11'($urandom_range(3, 40)),
                      31'($urandom >> $urandom_range(1, 20)),
                      31'($urandom >> $urandom_range(1, 20)),
                      10'($urandom_range(1, 30)),
                      $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h8000_0000))
                                          : 32'd214748365);
            random_phase(140);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        cmd = '0;
        pop = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        stall_left = 0;
        idle_on = 1;
        clock_ms = 32'd0;
        rd_ptr = '0;
        wr_ptr = '0;
        fill = 0;
        prob = '0;
        dly_now = '0;
        dly_prev = '0;
        burst = '0;
        regs = '{ecn_enable: 1'b0, qdelay_ref_ms: 16'd15, max_burst_ms: 16'd150,
                 buffer_limit: 11'd1024, alpha_gain: 31'd268435,
                 beta_gain: 31'd2684355, update_interval_ms: 10'd15,
                 mark_threshold: 32'd214748365};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_drop();
        test_early_drop();
        test_random();

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit, many times the slowest legal run
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: pie_aqm_queue.f
rtl/paq_pkg.sv
rtl/paq_ram.sv
rtl/paq_cfg.sv
rtl/paq_front.sv
rtl/paq_back.sv
rtl/pie_aqm_queue.sv
bench/tb_pie_aqm_queue.sv
